@@ hdl/cdps_pkg.sv @@
package cdps_pkg;

    localparam int PRESCALE_LIMIT_DEF   = 255;
    localparam int RATE_DIVIDER_MAX_DEF = 256;

    localparam int SRC_KHZ_W = 19;
    localparam int REQ_W     = 29;
    localparam int HZ_W      = 30;
    localparam int PRE_W     = 8;
    localparam int DIVR_W    = 9;
    localparam int PROD_W    = PRE_W + DIVR_W;
    localparam int LIM_W     = 17;
    localparam int CNT_W     = $clog2(HZ_W);

    localparam logic [SRC_KHZ_W-1:0] SRC_KHZ_RESET = SRC_KHZ_W'(480000);
    localparam logic [9:0]           KHZ_TO_HZ     = 10'd1000;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_DISABLED    = 2'd1,
        ST_UNREACHABLE = 2'd2
    } status_t;

    typedef struct packed {
        logic    start_q;
        logic    cap_q;
        logic    search_step;
        logic    start_d;
        logic    cap_d;
        logic    mul;
        logic    start_a;
        logic    cap_a;
        logic    out_load;
        status_t out_status;
    } cmd_t;

    typedef struct packed {
        logic req_zero;
        logic div_done;
        logic hit;
        logic last;
        logic out_free;
    } sts_t;

endpackage

@@ hdl/cdps_div.sv @@
module cdps_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [cdps_pkg::HZ_W-1:0]    num,
    input  logic [cdps_pkg::HZ_W-1:0]    den,
    output logic [cdps_pkg::HZ_W-1:0]    quo,
    output logic                         done
);

    localparam int W = cdps_pkg::HZ_W;

    logic [W-1:0]                  rem_reg, rem_next;
    logic [W-1:0]                  quo_reg, quo_next;
    logic [W-1:0]                  den_reg;
    logic [cdps_pkg::CNT_W-1:0]    cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;
    logic [W:0]                    rem_sh;

    always_comb begin
        rem_sh = {rem_reg, quo_reg[W-1]};
        if (rem_sh >= {1'b0, den_reg}) begin
            rem_next = W'(rem_sh - {1'b0, den_reg});
            quo_next = {quo_reg[W-2:0], 1'b1};
        end else begin
            rem_next = rem_sh[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == cdps_pkg::CNT_W'(W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

@@ hdl/cdps_datapath.sv @@
module cdps_datapath #(
    parameter int PRESCALE_LIMIT   = cdps_pkg::PRESCALE_LIMIT_DEF,
    parameter int RATE_DIVIDER_MAX = cdps_pkg::RATE_DIVIDER_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic [cdps_pkg::SRC_KHZ_W-1:0]    cfg_data,
    input  logic [cdps_pkg::REQ_W-1:0]        req,
    input  cdps_pkg::cmd_t                    cmd,
    output cdps_pkg::sts_t                    sts,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [cdps_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [cdps_pkg::M_TUSER_W-1:0]    m_tuser
);

    localparam int W = cdps_pkg::HZ_W;
    localparam logic [cdps_pkg::LIM_W-1:0] LIM_STEP =
        cdps_pkg::LIM_W'(2 * (RATE_DIVIDER_MAX + 1));
    localparam logic [cdps_pkg::PRE_W:0] PRE_END = (cdps_pkg::PRE_W + 1)'(PRESCALE_LIMIT);

    logic [cdps_pkg::SRC_KHZ_W-1:0]  src_khz_reg;
    logic [W-1:0]                    src_hz;
    logic [W-1:0]                    src_hz_reg;
    logic [W-1:0]                    q_reg;
    logic [cdps_pkg::PRE_W-1:0]      pre_reg;
    logic [cdps_pkg::LIM_W-1:0]      lim_reg;
    logic [cdps_pkg::DIVR_W-1:0]     divr_reg;
    logic [cdps_pkg::PROD_W-1:0]     prod_reg;
    logic [cdps_pkg::REQ_W-1:0]      ach_reg;
    logic [cdps_pkg::PRE_W:0]        pre_plus;
    logic [cdps_pkg::DIVR_W-1:0]     divr_m1;

    logic                            div_start;
    logic [W-1:0]                    div_num;
    logic [W-1:0]                    div_den;
    logic [W-1:0]                    div_quo;
    logic                            div_done;

    logic                            m_tvalid_reg;
    logic [cdps_pkg::PRE_W-1:0]      o_pre_reg;
    logic [cdps_pkg::PRE_W-1:0]      o_rm1_reg;
    logic [cdps_pkg::REQ_W-1:0]      o_ach_reg;
    cdps_pkg::status_t               o_st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_khz_reg <= cdps_pkg::SRC_KHZ_RESET;
        end else if (cfg_valid) begin
            src_khz_reg <= cfg_data;
        end
    end

    assign src_hz = W'(src_khz_reg) * W'(cdps_pkg::KHZ_TO_HZ);

    always_comb begin
        div_start = cmd.start_q | cmd.start_d | cmd.start_a;
        div_num   = src_hz_reg;
        div_den   = W'(prod_reg);
        if (cmd.start_q) begin
            div_num = src_hz;
            div_den = W'(req);
        end else if (cmd.start_d) begin
            div_num = q_reg;
            div_den = W'(pre_reg);
        end
    end

    cdps_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_quo),
        .done    (div_done)
    );

    assign pre_plus = {1'b0, pre_reg} + (cdps_pkg::PRE_W + 1)'(2);
    assign divr_m1  = divr_reg - 1'b1;

    always_ff @(posedge aclk) begin
        if (cmd.start_q) begin
            src_hz_reg <= src_hz;
        end
        if (cmd.cap_q) begin
            q_reg   <= div_quo;
            pre_reg <= cdps_pkg::PRE_W'(2);
            lim_reg <= LIM_STEP;
        end else if (cmd.search_step) begin
            pre_reg <= pre_plus[cdps_pkg::PRE_W-1:0];
            lim_reg <= lim_reg + LIM_STEP;
        end
        if (cmd.cap_d) begin
            divr_reg <= (div_quo == '0) ? cdps_pkg::DIVR_W'(1) : div_quo[cdps_pkg::DIVR_W-1:0];
        end
        if (cmd.mul) begin
            prod_reg <= cdps_pkg::PROD_W'(pre_reg) * cdps_pkg::PROD_W'(divr_reg);
        end
        if (cmd.cap_a) begin
            ach_reg <= div_quo[cdps_pkg::REQ_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            o_st_reg <= cmd.out_status;
            if (cmd.out_status == cdps_pkg::ST_OK) begin
                o_pre_reg <= pre_reg;
                o_rm1_reg <= divr_m1[cdps_pkg::PRE_W-1:0];
                o_ach_reg <= ach_reg;
            end else begin
                o_pre_reg <= '0;
                o_rm1_reg <= '0;
                o_ach_reg <= '0;
            end
        end
    end

    always_comb begin
        sts.req_zero = (req == '0);
        sts.div_done = div_done;
        sts.hit      = q_reg < W'(lim_reg);
        sts.last     = pre_plus >= PRE_END;
        sts.out_free = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, o_ach_reg, o_rm1_reg, o_pre_reg};
    assign m_tuser  = o_st_reg;

endmodule

@@ hdl/cdps_ctrl.sv @@
module cdps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  cdps_pkg::sts_t    sts,
    output cdps_pkg::cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DIV_Q  = 8'b0000_0010,
        S_SEARCH = 8'b0000_0100,
        S_DIV_D  = 8'b0000_1000,
        S_MUL    = 8'b0001_0000,
        S_ASTART = 8'b0010_0000,
        S_DIV_A  = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    cdps_pkg::status_t stat_reg, stat_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            stat_reg  <= cdps_pkg::ST_OK;
        end else begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        stat_next      = stat_reg;
        cmd            = '0;
        cmd.out_status = stat_reg;
        s_tready       = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (sts.req_zero) begin
                        stat_next  = cdps_pkg::ST_DISABLED;
                        state_next = S_OUT;
                    end else begin
                        stat_next   = cdps_pkg::ST_OK;
                        cmd.start_q = 1'b1;
                        state_next  = S_DIV_Q;
                    end
                end
            end
            S_DIV_Q: begin
                if (sts.div_done) begin
                    cmd.cap_q  = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (sts.hit) begin
                    cmd.start_d = 1'b1;
                    state_next  = S_DIV_D;
                end else if (sts.last) begin
                    stat_next  = cdps_pkg::ST_UNREACHABLE;
                    state_next = S_OUT;
                end else begin
                    cmd.search_step = 1'b1;
                end
            end
            S_DIV_D: begin
                if (sts.div_done) begin
                    cmd.cap_d  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_ASTART;
            end
            S_ASTART: begin
                cmd.start_a = 1'b1;
                state_next  = S_DIV_A;
            end
            S_DIV_A: begin
                if (sts.div_done) begin
                    cmd.cap_a  = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/clock_divider_pair_select_core.sv @@
// From the accepting edge to m_tvalid: a zero request goes straight to the output; an
// unreachable one ends after the quotient division and the full prescaler search; else three
// passes of one shared radix-2 divider, control states and one search step per prescaler tried.
// One request is handled at a time; the next is taken the cycle after the result is loaded
// into the output register.
// Reset: aresetn synchronous active low; clears control and sets source clock to 480000 kHz.
module clock_divider_pair_select_core #(
    parameter int PRESCALE_LIMIT   = cdps_pkg::PRESCALE_LIMIT_DEF,
    parameter int RATE_DIVIDER_MAX = cdps_pkg::RATE_DIVIDER_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cdps_pkg::SRC_KHZ_W-1:0]    cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cdps_pkg::S_TDATA_W-1:0]    s_tdata,  // [28:0] requested_hz
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cdps_pkg::M_TDATA_W-1:0]    m_tdata,  // prescale, rate_minus_one, achieved_hz
    output logic [cdps_pkg::M_TUSER_W-1:0]    m_tuser   // [1:0] status
);

    cdps_pkg::cmd_t cmd;
    cdps_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    cdps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cdps_datapath #(
        .PRESCALE_LIMIT   (PRESCALE_LIMIT),
        .RATE_DIVIDER_MAX (RATE_DIVIDER_MAX)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .req       (s_tdata[cdps_pkg::REQ_W-1:0]),
        .cmd       (cmd),
        .sts       (sts),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
